// ----- rtl/pwa_pkg.sv -----
// Package for the polygon winding-angle test: sizes, angle types, CORDIC
// arctangent table and the wrapped angle difference.
// No dependencies; every other file imports it.
package pwa_pkg;

    localparam int ANGLE_BITS  = 16;
    localparam int FIELD_W     = 24;                 // coordinate field width
    localparam int COORD_BITS  = 24;                 // low bits used, 16..FIELD_W
    localparam int DIFF_W      = COORD_BITS + 1;
    localparam int SCALE_SHIFT = 60 - COORD_BITS;
    localparam int DATA_W      = 64;                 // CORDIC x/y datapath
    localparam int Z_W         = 32;                 // turn accumulator
    localparam int SUM_W       = 32;
    localparam int ITER_W      = $clog2(ANGLE_BITS);
    localparam int TAB_W       = 5;                  // atan table index, 24 entries

    typedef logic signed [ANGLE_BITS-1:0] angle_t;
    typedef logic signed [ANGLE_BITS:0]   adiff_t;
    typedef logic signed [DIFF_W-1:0]     coord_diff_t;
    typedef logic signed [SUM_W-1:0]      sum_t;

    typedef struct packed {
        logic step;      // fold in the current CORDIC angle
        logic last;      // closing vertex of the polygon
    } step_t;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [Z_W-1:0] atan_turn(input logic [TAB_W-1:0] idx);
        logic [Z_W-1:0] r;
        unique case (idx)
            5'd0:    r = 32'h2000_0000;
            5'd1:    r = 32'h12E4_051E;
            5'd2:    r = 32'h09FB_385B;
            5'd3:    r = 32'h0511_11D4;
            5'd4:    r = 32'h028B_0D43;
            5'd5:    r = 32'h0145_D7E1;
            5'd6:    r = 32'h00A2_F61E;
            5'd7:    r = 32'h0051_7C55;
            5'd8:    r = 32'h0028_BE53;
            5'd9:    r = 32'h0014_5F2F;
            5'd10:   r = 32'h000A_2F98;
            5'd11:   r = 32'h0005_17CC;
            5'd12:   r = 32'h0002_8BE6;
            5'd13:   r = 32'h0001_45F3;
            5'd14:   r = 32'h0000_A2F9;
            5'd15:   r = 32'h0000_517C;
            5'd16:   r = 32'h0000_28BE;
            5'd17:   r = 32'h0000_145F;
            5'd18:   r = 32'h0000_0A2F;
            5'd19:   r = 32'h0000_0517;
            5'd20:   r = 32'h0000_028B;
            5'd21:   r = 32'h0000_0145;
            5'd22:   r = 32'h0000_00A2;
            5'd23:   r = 32'h0000_0051;
            default: r = '0;
        endcase
        return r;
    endfunction

    // Low COORD_BITS of a field, read as two's complement
    function automatic logic signed [COORD_BITS-1:0] coord(input logic [FIELD_W-1:0] f);
        return signed'(f[COORD_BITS-1:0]);
    endfunction

    // to - from, folded into [-half, +half]; exactly +-half is kept.
    // Adding or subtracting a full turn flips only the top bit of the
    // ANGLE_BITS+1 wide difference.
    function automatic adiff_t wrap_diff(input angle_t from, input angle_t to);
        localparam adiff_t HALF  = adiff_t'(1) <<< (ANGLE_BITS - 1);
        localparam adiff_t NHALF = -HALF;
        adiff_t raw;
        raw = adiff_t'(to) - adiff_t'(from);
        if (raw > HALF || raw < NHALF)
        begin
            raw = {~raw[ANGLE_BITS], raw[ANGLE_BITS-1:0]};
        end
        return raw;
    endfunction

endpackage

// ----- rtl/pwa_if.sv -----
// Valid/ready channel interfaces for vertex input and test result.
// Depends on pwa_pkg for field widths.
interface pwa_vertex_if;
    import pwa_pkg::*;

    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] vertex_x;
    logic [FIELD_W-1:0] vertex_y;
    logic [FIELD_W-1:0] query_x;
    logic [FIELD_W-1:0] query_y;
    logic               last_vertex;

    modport source (output valid, vertex_x, vertex_y, query_x, query_y, last_vertex,
                    input ready);
    modport sink   (input valid, vertex_x, vertex_y, query_x, query_y, last_vertex,
                    output ready);
endinterface

interface pwa_result_if;
    import pwa_pkg::*;

    logic             valid;
    logic             ready;
    logic             inside_res;
    logic [SUM_W-1:0] winding_sum;

    modport source (output valid, inside_res, winding_sum, input ready);
    modport sink   (input valid, inside_res, winding_sum, output ready);
endinterface

// ----- rtl/pwa_cordic.sv -----
// Iterative vectoring CORDIC: angle of (dx, dy) as a signed binary angle,
// one micro-rotation per cycle through a single shift/add unit.
// Depends on pwa_pkg.
module pwa_cordic (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  pwa_pkg::coord_diff_t dx,
    input  pwa_pkg::coord_diff_t dy,
    output logic                 done,
    output pwa_pkg::angle_t      angle
);
    import pwa_pkg::*;

    localparam logic [1:0] C_IDLE = 2'd0;
    localparam logic [1:0] C_RUN  = 2'd1;
    localparam logic [1:0] C_FIN  = 2'd2;

    localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(ANGLE_BITS - 1);
    localparam logic [Z_W-1:0]    HALF_TURN = Z_W'(1) << (Z_W - 1);
    localparam logic [Z_W-1:0]    ROUND_BIT = Z_W'(1) << (Z_W - 1 - ANGLE_BITS);

    logic [1:0]               state_reg, state_next;
    logic [ITER_W-1:0]        cnt_reg, cnt_next;
    logic signed [DATA_W-1:0] x_reg, x_next;
    logic signed [DATA_W-1:0] y_reg, y_next;
    logic [Z_W-1:0]           z_reg, z_next;

    logic signed [DATA_W-1:0] x_load, y_load, x_sh, y_sh;
    logic [Z_W-1:0]           z_round;

    assign x_load = DATA_W'(dx) <<< SCALE_SHIFT;
    assign y_load = DATA_W'(dy) <<< SCALE_SHIFT;
    assign x_sh   = x_reg >>> cnt_reg;     // arithmetic shift: floor
    assign y_sh   = y_reg >>> cnt_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        unique case (state_reg)
            C_IDLE:
            begin
                if (start)
                begin
                    cnt_next = '0;
                    if (dx == '0 && dy == '0)
                    begin
                        z_next     = '0;   // zero vector reads as angle zero
                        state_next = C_FIN;
                    end
                    else
                    begin
                        if (dx < 0)
                        begin
                            x_next = -x_load;
                            y_next = -y_load;
                            z_next = HALF_TURN;
                        end
                        else
                        begin
                            x_next = x_load;
                            y_next = y_load;
                            z_next = '0;
                        end
                        state_next = C_RUN;
                    end
                end
            end
            C_RUN:
            begin
                if (y_reg < 0)
                begin
                    x_next = x_reg - y_sh;
                    y_next = y_reg + x_sh;
                    z_next = z_reg - atan_turn(TAB_W'(cnt_reg));
                end
                else
                begin
                    x_next = x_reg + y_sh;
                    y_next = y_reg - x_sh;
                    z_next = z_reg + atan_turn(TAB_W'(cnt_reg));
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_ITER)
                begin
                    state_next = C_FIN;
                end
            end
            C_FIN:
            begin
                state_next = C_IDLE;
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    // z holds until the next start, so the angle stays valid after done
    assign z_round = z_reg + ROUND_BIT;
    assign angle   = signed'(z_round[Z_W-1 -: ANGLE_BITS]);
    assign done    = (state_reg == C_FIN);

endmodule

// ----- rtl/pwa_wind.sv -----
// Winding accumulator: folds vertex angles into the wrapped angle sum and
// holds the result register for the output channel.
// Depends on pwa_pkg and pwa_result_if.
module pwa_wind (
    input  logic            clk,
    input  logic            rst_n,
    input  pwa_pkg::step_t  ctl,
    input  pwa_pkg::angle_t angle,
    output logic            out_full,
    pwa_result_if.source    results
);
    import pwa_pkg::*;

    localparam sum_t HALF_SUM  = sum_t'(1) <<< (ANGLE_BITS - 1);
    localparam sum_t NHALF_SUM = -HALF_SUM;

    angle_t first_reg, first_next;
    angle_t prev_reg, prev_next;
    sum_t   acc_reg, acc_next;
    logic   started_reg, started_next;
    sum_t   sum_reg, sum_next;
    logic   valid_reg, valid_next;

    adiff_t                d_edge, d_close;
    logic signed [ANGLE_BITS+1:0] d_both;

    assign d_edge  = wrap_diff(prev_reg, angle);
    assign d_close = wrap_diff(angle, first_reg);
    assign d_both  = (ANGLE_BITS+2)'(d_edge) + (ANGLE_BITS+2)'(d_close);

    always_comb
    begin
        first_next   = first_reg;
        prev_next    = prev_reg;
        acc_next     = acc_reg;
        started_next = started_reg;
        sum_next     = sum_reg;
        valid_next   = valid_reg && !results.ready;
        if (ctl.step)
        begin
            if (!started_reg)
            begin
                first_next   = angle;
                prev_next    = angle;
                acc_next     = '0;
                started_next = 1'b1;
            end
            else
            begin
                acc_next  = acc_reg + SUM_W'(d_edge);
                prev_next = angle;
            end
            if (ctl.last)
            begin
                // a polygon of one vertex closes with sum zero
                sum_next     = started_reg ? (acc_reg + SUM_W'(d_both)) : '0;
                valid_next   = 1'b1;
                first_next   = '0;
                prev_next    = '0;
                acc_next     = '0;
                started_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg   <= '0;
            prev_reg    <= '0;
            acc_reg     <= '0;
            started_reg <= 1'b0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            first_reg   <= first_next;
            prev_reg    <= prev_next;
            acc_reg     <= acc_next;
            started_reg <= started_next;
            valid_reg   <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
    end

    assign out_full            = valid_reg && !results.ready;
    assign results.valid       = valid_reg;
    assign results.winding_sum = sum_reg;
    assign results.inside_res  = (sum_reg >= HALF_SUM) || (sum_reg <= NHALF_SUM);

endmodule

// ----- rtl/polygon_winding_angle_test.sv -----
// Top level of the point-in-polygon winding-angle test: sequencer around
// the shared CORDIC unit and the winding accumulator.
// Depends on pwa_pkg, pwa_if, pwa_cordic and pwa_wind.
//
//   channel    dir  payload                                          transfer
//   vertices   in   vertex_x/y, query_x/y (24b signed), last_vertex  valid & ready
//   results    out  inside_res, winding_sum (32b signed)             valid & ready
//
// A vertex is handled in steps: the CORDIC is loaded, runs its micro-rotations,
// rounds the angle, and the angle is accumulated. A vertex equal to
// the query point skips the rotations. vertices.ready is high only
// while the sequencer is idle. A result waits in its output register; the next
// polygon's vertices are still taken, and only a closing vertex waits for it
// to be transferred. Reset clears the sequencer and starts a new polygon.
module polygon_winding_angle_test (
    input  logic         clk,
    input  logic         rst_n,
    pwa_vertex_if.sink   vertices,
    pwa_result_if.source results
);
    import pwa_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ANGLE = 2'd1;
    localparam logic [1:0] S_ACC   = 2'd2;

    logic [1:0]  state_reg, state_next;
    logic        last_reg, last_next;
    logic        accept;
    logic        cordic_done;
    logic        out_full;
    angle_t      angle;
    coord_diff_t dx, dy;
    step_t       ctl;

    assign vertices.ready = (state_reg == S_IDLE);
    assign accept         = vertices.valid && vertices.ready;

    assign dx = DIFF_W'(coord(vertices.vertex_x)) - DIFF_W'(coord(vertices.query_x));
    assign dy = DIFF_W'(coord(vertices.vertex_y)) - DIFF_W'(coord(vertices.query_y));

    always_comb
    begin
        state_next = state_reg;
        last_next  = last_reg;
        ctl.step   = 1'b0;
        ctl.last   = last_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    last_next  = vertices.last_vertex;
                    state_next = S_ANGLE;
                end
            end
            S_ANGLE:
            begin
                if (cordic_done)
                begin
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                // closing vertex waits until the result register is free
                if (!(last_reg && out_full))
                begin
                    ctl.step   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            last_reg  <= last_next;
        end
    end

    pwa_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .dx    (dx),
        .dy    (dy),
        .done  (cordic_done),
        .angle (angle)
    );

    pwa_wind u_wind (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .angle    (angle),
        .out_full (out_full),
        .results  (results)
    );

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking bench for polygon_winding_angle_test: directed table plus random
// polygons, each result compared with a fixed-point winding predictor or a typed row.
// Depends on pwa_pkg and the pwa_vertex_if / pwa_result_if channel interfaces.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pwa_pkg::*;

    localparam int                 NUM_ITEMS    = 1350;
    localparam int                 NUM_DIRECTED = 21;
    localparam int                 DRAIN_CYCLES = 4 * (ANGLE_BITS + 3);
    localparam logic [FIELD_W-1:0] CMAX = 24'h7F_FFFF;
    localparam logic [FIELD_W-1:0] CMIN = 24'h80_0000;
    localparam logic [FIELD_W-1:0] CZ   = 24'h00_0000;

    typedef struct packed {
        logic [FIELD_W-1:0] vx;
        logic [FIELD_W-1:0] vy;
        logic [FIELD_W-1:0] qx;
        logic [FIELD_W-1:0] qy;
        logic               last;
    } vertex_t;

    typedef struct packed {
        logic             in_poly;
        logic [SUM_W-1:0] sum;
    } winding_result_t;

    typedef struct packed {
        vertex_t         v;
        logic            typed;     // expectation given in the row itself
        winding_result_t res;
    } directed_row_t;

    localparam winding_result_t ZERO_WINDING = '0;

    logic clk = 1'b0;
    logic rst_n;

    pwa_vertex_if vertices();
    pwa_result_if results();

    polygon_winding_angle_test dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .vertices (vertices),
        .results  (results)
    );

    always #5 clk = ~clk;

    // predictor state
    angle_t          pred_first;
    angle_t          pred_prev;
    logic [SUM_W-1:0] pred_accum;
    bit              pred_started;

    winding_result_t expected_windings[$];
    int              mismatches = 0;
    int              sent_items = 0;
    bit              src_burst  = 1'b0;
    bit              sink_burst = 1'b0;

    int dir_x[8] = '{1, 1, 0, -1, -1, -1, 0, 1};
    int dir_y[8] = '{0, 1, 1, 1, 0, -1, -1, -1};

    directed_row_t directed_rows [NUM_DIRECTED];

    function automatic logic [31:0] atan_step(input int i);
        case (i)
            0:       return 32'h2000_0000;
            1:       return 32'h12E4_051E;
            2:       return 32'h09FB_385B;
            3:       return 32'h0511_11D4;
            4:       return 32'h028B_0D43;
            5:       return 32'h0145_D7E1;
            6:       return 32'h00A2_F61E;
            7:       return 32'h0051_7C55;
            8:       return 32'h0028_BE53;
            9:       return 32'h0014_5F2F;
            10:      return 32'h000A_2F98;
            11:      return 32'h0005_17CC;
            12:      return 32'h0002_8BE6;
            13:      return 32'h0001_45F3;
            14:      return 32'h0000_A2F9;
            15:      return 32'h0000_517C;
            16:      return 32'h0000_28BE;
            17:      return 32'h0000_145F;
            18:      return 32'h0000_0A2F;
            19:      return 32'h0000_0517;
            20:      return 32'h0000_028B;
            21:      return 32'h0000_0145;
            22:      return 32'h0000_00A2;
            23:      return 32'h0000_0051;
            default: return 32'h0;
        endcase
    endfunction

    function automatic longint coord_of(input logic [FIELD_W-1:0] f);
        logic signed [COORD_BITS-1:0] c;
        c = f[COORD_BITS-1:0];
        return longint'(c);
    endfunction

    // vectoring CORDIC, binary angle rounded half up
    function automatic angle_t cordic_angle(input longint dx, input longint dy);
        longint      x;
        longint      y;
        longint      xs;
        longint      ys;
        logic [31:0] z;
        angle_t      a;
        if (dx == 0 && dy == 0)
            return '0;
        x = dx <<< SCALE_SHIFT;
        y = dy <<< SCALE_SHIFT;
        z = 32'h0;
        if (x < 0)
        begin
            x = -x;
            y = -y;
            z = 32'h8000_0000;
        end
        for (int i = 0; i < ANGLE_BITS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y < 0)
            begin
                x = x - ys;
                y = y + xs;
                z = z - atan_step(i);
            end
            else
            begin
                x = x + ys;
                y = y - xs;
                z = z + atan_step(i);
            end
        end
        z = z + (32'h1 << (31 - ANGLE_BITS));
        a = z[31 -: ANGLE_BITS];
        return a;
    endfunction

    // to - from folded into [-half, +half], exact half turn kept
    function automatic int angle_delta(input angle_t from, input angle_t to);
        int raw;
        raw = int'(to) - int'(from);
        if (raw > (1 << (ANGLE_BITS - 1)))
            raw = raw - (1 << ANGLE_BITS);
        else if (raw < -(1 << (ANGLE_BITS - 1)))
            raw = raw + (1 << ANGLE_BITS);
        return raw;
    endfunction

    // Folds one vertex into the running winding; returns 1 when it closes a polygon.
    function automatic bit track_vertex(input vertex_t v, output winding_result_t res);
        angle_t           a;
        logic [SUM_W-1:0] total;
        logic [SUM_W-1:0] mag;
        a   = cordic_angle(coord_of(v.vx) - coord_of(v.qx), coord_of(v.vy) - coord_of(v.qy));
        res = ZERO_WINDING;
        if (!pred_started)
        begin
            pred_first   = a;
            pred_prev    = a;
            pred_accum   = '0;
            pred_started = 1'b1;
        end
        else
        begin
            pred_accum = pred_accum + angle_delta(pred_prev, a);
            pred_prev  = a;
        end
        if (!v.last)
            return 1'b0;
        total       = pred_accum + angle_delta(a, pred_first);
        mag         = total[SUM_W-1] ? -total : total;
        res.in_poly = (mag >= (1 << (ANGLE_BITS - 1)));
        res.sum     = total;
        pred_first   = '0;
        pred_prev    = '0;
        pred_accum   = '0;
        pred_started = 1'b0;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t ns mismatch: %s", $time, what);
        mismatches++;
    endtask

    task automatic send_vertex(input vertex_t v, input bit typed, input winding_result_t typed_res);
        int              gap;
        winding_result_t res;
        gap = src_burst ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            vertices.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        vertices.valid       <= 1'b1;
        vertices.vertex_x    <= v.vx;
        vertices.vertex_y    <= v.vy;
        vertices.query_x     <= v.qx;
        vertices.query_y     <= v.qy;
        vertices.last_vertex <= v.last;
        do @(posedge clk); while (vertices.ready !== 1'b1);
        sent_items++;
        if (track_vertex(v, res))
            expected_windings.insert(expected_windings.size(), typed ? typed_res : res);
    endtask

    function automatic logic [FIELD_W-1:0] rand_coord();
        case ($urandom_range(0, 11))
            0:       return CMAX;
            1:       return CMIN;
            2:       return CZ;
            default: return FIELD_W'($urandom);
        endcase
    endfunction

    function automatic int rand_radius(input int scale);
        return (1 << scale) | ($urandom & ((1 << scale) - 1));
    endfunction

    task automatic send_polygon();
        vertex_t v;
        int      kind;
        int      n;
        int      turns;
        int      d0;
        int      sense;
        int      scale;
        int      d;
        kind      = $urandom_range(0, 9);
        src_burst = ($urandom_range(0, 5) == 0);
        v.qx      = rand_coord();
        v.qy      = rand_coord();
        if (kind == 9)
        begin
            // stray vertex, may close whatever polygon is open
            v.vx   = rand_coord();
            v.vy   = rand_coord();
            v.last = ($urandom_range(0, 3) == 0);
            send_vertex(v, 1'b0, ZERO_WINDING);
        end
        else if (kind == 8)
        begin
            n     = $urandom_range(1, 10);
            scale = $urandom_range(0, 23);
            for (int k = 0; k < n; k++)
            begin
                if (scale == 23)
                begin
                    v.vx = rand_coord();
                    v.vy = rand_coord();
                end
                else
                begin
                    v.vx = v.qx + FIELD_W'($urandom_range(0, 2 * (1 << scale)) - (1 << scale));
                    v.vy = v.qy + FIELD_W'($urandom_range(0, 2 * (1 << scale)) - (1 << scale));
                end
                v.last = (k == n - 1);
                send_vertex(v, 1'b0, ZERO_WINDING);
            end
        end
        else
        begin
            // star around the query: winds once (or twice) either way
            turns = (kind == 7) ? 2 : 1;
            n     = turns * $urandom_range(3, 8);
            d0    = $urandom_range(0, 7);
            sense = $urandom_range(0, 1) ? 1 : -1;
            scale = $urandom_range(0, 21);
            for (int k = 0; k < n; k++)
            begin
                d      = (d0 + sense * ((k * 8 * turns) / n)) & 7;
                v.vx   = v.qx + FIELD_W'(dir_x[d] * rand_radius(scale));
                v.vy   = v.qy + FIELD_W'(dir_y[d] * rand_radius(scale));
                v.last = (k == n - 1);
                send_vertex(v, 1'b0, ZERO_WINDING);
            end
        end
    endtask

    // result side: random stalls, then compare each transfer
    initial
    begin
        int              gap;
        winding_result_t exp;
        results.ready <= 1'b0;
        forever
        begin
            if ($urandom_range(0, 7) == 0)
                sink_burst = !sink_burst;
            gap = sink_burst ? 0 : $urandom_range(0, 15);
            if (gap > 0)
            begin
                results.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            results.ready <= 1'b1;
            do @(posedge clk); while (results.valid !== 1'b1 || rst_n !== 1'b1);
            if (expected_windings.size() == 0)
                report_mismatch($sformatf("unexpected result inside=%0b sum=%0d",
                                          results.inside_res, $signed(results.winding_sum)));
            else
            begin
                exp = expected_windings.pop_front();
                if (results.inside_res !== exp.in_poly)
                    report_mismatch($sformatf("inside_res got %0b want %0b",
                                              results.inside_res, exp.in_poly));
                if (results.winding_sum !== exp.sum)
                    report_mismatch($sformatf("winding_sum got %0d want %0d",
                                              $signed(results.winding_sum), $signed(exp.sum)));
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        directed_rows = '{
            // single vertex, extreme coordinates
            '{'{CMAX, CMIN, CZ, CZ, 1'b1}, 1'b1, ZERO_WINDING},
            // vertex on the query point, alone
            '{'{24'h12_3456, 24'hFE_DCBA, 24'h12_3456, 24'hFE_DCBA, 1'b1}, 1'b1, ZERO_WINDING},
            // counter-clockwise square around the query
            '{'{24'd1000, CZ, CZ, CZ, 1'b0}, 1'b0, ZERO_WINDING},
            '{'{CZ, 24'd1000, CZ, CZ, 1'b0}, 1'b0, ZERO_WINDING},
            '{'{-24'sd1000, CZ, CZ, CZ, 1'b0}, 1'b0, ZERO_WINDING},
            '{'{CZ, -24'sd1000, CZ, CZ, 1'b1}, 1'b0, ZERO_WINDING},
            // triangle away from the query
            '{'{24'd5000, 24'd5000, CZ, CZ, 1'b0}, 1'b0, ZERO_WINDING},
            '{'{24'd9000, 24'd5000, CZ, CZ, 1'b0}, 1'b0, ZERO_WINDING},
            '{'{24'd7000, 24'd9000, CZ, CZ, 1'b1}, 1'b0, ZERO_WINDING},
            // two vertices always close to a zero sum; largest differences
            '{'{CMAX, CMAX, CMIN, CMIN, 1'b0}, 1'b0, ZERO_WINDING},
            '{'{CMIN, CMIN, CMAX, CMAX, 1'b1}, 1'b1, ZERO_WINDING},
            // clockwise square on the coordinate extremes
            '{'{CMAX, CZ, CZ, CZ, 1'b0}, 1'b0, ZERO_WINDING},
            '{'{CZ, CMIN, CZ, CZ, 1'b0}, 1'b0, ZERO_WINDING},
            '{'{CMIN, CZ, CZ, CZ, 1'b0}, 1'b0, ZERO_WINDING},
            '{'{CZ, CMAX, CZ, CZ, 1'b1}, 1'b0, ZERO_WINDING},
            // vertex on the query inside a longer polygon
            '{'{24'd100, 24'd200, 24'd100, 24'd200, 1'b0}, 1'b0, ZERO_WINDING},
            '{'{-24'sd300, 24'd200, 24'd100, 24'd200, 1'b0}, 1'b0, ZERO_WINDING},
            '{'{24'd100, -24'sd900, 24'd100, 24'd200, 1'b1}, 1'b0, ZERO_WINDING},
            // negative x axis: half-turn angle
            '{'{-24'sd1000, -24'sd50, -24'sd50, -24'sd50, 1'b0}, 1'b0, ZERO_WINDING},
            '{'{-24'sd50, -24'sd1000, -24'sd50, -24'sd50, 1'b0}, 1'b0, ZERO_WINDING},
            '{'{-24'sd50, -24'sd49, -24'sd50, -24'sd50, 1'b1}, 1'b0, ZERO_WINDING}
        };

        pred_first   = '0;
        pred_prev    = '0;
        pred_accum   = '0;
        pred_started = 1'b0;

        rst_n                <= 1'b0;
        vertices.valid       <= 1'b0;
        vertices.vertex_x    <= '0;
        vertices.vertex_y    <= '0;
        vertices.query_x     <= '0;
        vertices.query_y     <= '0;
        vertices.last_vertex <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_DIRECTED; i++)
            send_vertex(directed_rows[i].v, directed_rows[i].typed, directed_rows[i].res);

        while (sent_items < NUM_ITEMS)
            send_polygon();
        vertices.valid <= 1'b0;

        while (expected_windings.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
